// ----- rtl/core/histogram_median_engine_assert.svh -----
// Assertion macros used by the histogram median engine checker.
`ifndef HISTOGRAM_MEDIAN_ENGINE_ASSERT_SVH
`define HISTOGRAM_MEDIAN_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HME_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("histogram median engine check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HME_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("histogram median engine check failed");

`endif

// ----- rtl/core/hme_pkg.sv -----
// Types and constants of the histogram median engine.
package hme_pkg;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_SKIP = 2'd1;

    localparam logic [13:0] WHITE_RESET = 14'h3FFF;
    localparam logic [31:0] BIN_MAX     = 32'hFFFF_FFFF;

    typedef struct packed {
        op_t         op;
        logic [15:0] sample;
        logic        last_in_batch;
    } hme_req_t;

    typedef struct packed {
        logic [13:0] median_level;
        logic [31:0] sample_total;
    } hme_rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_WR,
        ST_SCAN,
        ST_RESULT
    } state_t;

endpackage

// ----- rtl/core/histogram_median_engine.sv -----
// Histogram median engine: bin store, sample counting, median scan and clear sweep.
// Usage:
//   The request channel (req_valid/req_ready/req_data) carries one request per
//   handshake: add a sample, query the median, or clear the histogram.
//   The response channel (rsp_valid/rsp_ready/rsp_data) returns one response
//   per median query: the median level and the saturating sample total.
//   The config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes
//   white_level (index 0) and sample_skip (index 1); it is always ready.
//   Write config only while no request is in flight.
// Timing:
//   An add reads, then writes back, its bin in the single bin memory; a skipped
//   sample does not touch the memory. A query walks bins from level 0 at one
//   bin per cycle up to k, the last bin summed (the median level, or the top
//   bin when no bin passes half the total); rsp_valid then rises, later while
//   the output register is full, and the next request is taken only after the
//   response is registered. A clear zeroes every bin in turn.
// Reset:
//   Reset starts a clearing pass over the bin memory; requests are refused
//   during it, config writes are taken.
// Stall: a waiting response does not block adds or clears; a finished query
//   holds in its result state until the output register frees up.
module histogram_median_engine #(
    parameter int NUM_BINS = 16384
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  hme_pkg::hme_req_t                   req_data,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output hme_pkg::hme_rsp_t                   rsp_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hme_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [15:0]                         cfg_data
);
    import hme_pkg::*;

    localparam int BIN_W = $clog2(NUM_BINS);
    localparam int CNT_W = BIN_W + 1;
    localparam int RUN_W = 32 + BIN_W;
    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

    // Bin store: one write port, one registered read port.
    logic [31:0]      bin_mem [NUM_BINS];
    logic             mem_we;
    logic [BIN_W-1:0] mem_waddr;
    logic [31:0]      mem_wdata;
    logic [BIN_W-1:0] mem_raddr;
    logic [31:0]      rd_data_reg;

    // Control state.
    state_t           state_reg, state_next;
    logic [BIN_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic             pend_reg, pend_next;
    logic [BIN_W-1:0] pend_idx_reg, pend_idx_next;
    logic [31:0]      total_reg, total_next;
    logic [15:0]      phase_reg, phase_next;
    logic [13:0]      white_level_reg, white_level_next;
    logic [15:0]      sample_skip_reg, sample_skip_next;
    logic             rsp_valid_reg, rsp_valid_next;

    // Payload state.
    logic [RUN_W-1:0] run_reg, run_next;
    logic [BIN_W-1:0] add_addr_reg, add_addr_next;
    logic [13:0]      median_reg, median_next;
    hme_rsp_t         rsp_data_reg, rsp_data_next;

    logic             req_fire;
    logic [BIN_W-1:0] top_bin;
    logic [BIN_W-1:0] sample_bin;
    logic [RUN_W-1:0] run_sum;
    logic [RUN_W-1:0] middle;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // Effective top bin and clamped sample bin.
    assign top_bin    = (17'(white_level_reg) > 17'(LAST_BIN)) ? LAST_BIN
                                                               : BIN_W'(white_level_reg);
    assign sample_bin = (17'(req_data.sample) > 17'(top_bin)) ? top_bin
                                                              : BIN_W'(req_data.sample);

    assign run_sum = run_reg + RUN_W'(rd_data_reg);
    assign middle  = RUN_W'(total_reg >> 1);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bin_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= bin_mem[mem_raddr];
    end

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        scan_cnt_next    = scan_cnt_reg;
        pend_next        = 1'b0;
        pend_idx_next    = pend_idx_reg;
        total_next       = total_reg;
        phase_next       = phase_reg;
        white_level_next = white_level_reg;
        sample_skip_next = sample_skip_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        run_next         = run_reg;
        add_addr_next    = add_addr_reg;
        median_next      = median_reg;
        rsp_data_next    = rsp_data_reg;
        mem_we           = 1'b0;
        mem_waddr        = clr_cnt_reg;
        mem_wdata        = '0;
        mem_raddr        = sample_bin;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_WHITE_LEVEL: white_level_next = cfg_data[13:0];
                CFG_SAMPLE_SKIP: sample_skip_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Zero one bin per cycle.
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_BIN)
                begin
                    clr_cnt_next = '0;
                    state_next   = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    unique case (req_data.op)
                        OP_ADD:
                        begin
                            if (phase_reg == '0)
                            begin
                                // Read the bin now, write it back next cycle.
                                mem_raddr     = sample_bin;
                                add_addr_next = sample_bin;
                                if (total_reg != BIN_MAX)
                                begin
                                    total_next = total_reg + 1'b1;
                                end
                                state_next = ST_ADD_WR;
                            end
                            if (req_data.last_in_batch || phase_reg >= sample_skip_reg)
                            begin
                                phase_next = '0;
                            end
                            else
                            begin
                                phase_next = phase_reg + 1'b1;
                            end
                        end
                        OP_QUERY:
                        begin
                            scan_cnt_next = '0;
                            run_next      = '0;
                            state_next    = ST_SCAN;
                        end
                        OP_CLEAR:
                        begin
                            total_next   = '0;
                            clr_cnt_next = '0;
                            state_next   = ST_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ADD_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = add_addr_reg;
                mem_wdata  = (rd_data_reg == BIN_MAX) ? BIN_MAX : rd_data_reg + 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                // Issue the next bin read while the previous one is summed.
                mem_raddr = scan_cnt_reg[BIN_W-1:0];
                if (scan_cnt_reg <= CNT_W'(top_bin))
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = scan_cnt_reg[BIN_W-1:0];
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    run_next = run_sum;
                    if (run_sum > middle)
                    begin
                        median_next = 14'(pend_idx_reg);
                        pend_next   = 1'b0;
                        state_next  = ST_RESULT;
                    end
                    else if (pend_idx_reg == top_bin)
                    begin
                        median_next = '0;
                        pend_next   = 1'b0;
                        state_next  = ST_RESULT;
                    end
                end
            end
            ST_RESULT:
            begin
                // Hold until the output register is free.
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next             = 1'b1;
                    rsp_data_next.median_level = median_reg;
                    rsp_data_next.sample_total = total_reg;
                    state_next                 = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            scan_cnt_reg    <= '0;
            pend_reg        <= 1'b0;
            pend_idx_reg    <= '0;
            total_reg       <= '0;
            phase_reg       <= '0;
            white_level_reg <= WHITE_RESET;
            sample_skip_reg <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            scan_cnt_reg    <= scan_cnt_next;
            pend_reg        <= pend_next;
            pend_idx_reg    <= pend_idx_next;
            total_reg       <= total_next;
            phase_reg       <= phase_next;
            white_level_reg <= white_level_next;
            sample_skip_reg <= sample_skip_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg      <= run_next;
        add_addr_reg <= add_addr_next;
        median_reg   <= median_next;
        rsp_data_reg <= rsp_data_next;
    end

endmodule

// ----- rtl/core/hme_checker.sv -----
// Port-level checker for the histogram median engine, bound to the top level.
`include "histogram_median_engine_assert.svh"

module hme_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input hme_pkg::hme_req_t             req_data,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic                          cfg_ready
);
    import hme_pkg::*;

    // Hold a stalled response.
    `HME_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)

    // Drop ready while a query scan or a clear sweep runs.
    `HME_ASSERT_NEXT(a_query_busy, clk, rst_n,
        req_valid && req_ready && req_data.op == OP_QUERY, !req_ready)
    `HME_ASSERT_NEXT(a_clear_busy, clk, rst_n,
        req_valid && req_ready && req_data.op == OP_CLEAR, !req_ready)

    // A new response only follows a busy cycle, the result state of a query.
    `HME_ASSERT_IMPL(a_rsp_after_scan, clk, rst_n, $rose(rsp_valid), !$past(req_ready))

    // Config writes are never refused.
    `HME_ASSERT_IMPL(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready)

endmodule

bind histogram_median_engine hme_checker u_hme_checker (.*);
